// ===== design/obbcd_pkg.sv =====
// Shared types, widths and reset constants for the oriented box closest point core.
// Used by every module of the core and by its checker; depends on nothing.
package obbcd_pkg;

  // Field and register widths.
  localparam int CoordW    = 16;
  localparam int RegW      = 48;
  localparam int DistW     = 40;

  // Internal arithmetic widths.
  localparam int OffW      = CoordW + 1;          // point minus center
  localparam int ProdW     = OffW + CoordW;       // offset times axis component
  localparam int ProjW     = ProdW + 2;           // sum of three products
  localparam int FracShift = 14;                  // Q8.8 half-extent to Q.22
  localparam int LimW      = CoordW + FracShift;  // scaled half-extent, unsigned
  localparam int ClampW    = LimW + 1;            // clamped projection, signed
  localparam int ExcW      = ProjW;               // excess beyond the extent
  localparam int ExcShift  = 11;                  // Q.22 to Q.11
  localparam int E11W      = ExcW + 1 - ExcShift;
  localparam int SqW       = 2 * E11W;
  localparam int SqSumW    = SqW + 2;
  localparam int DistShift = 6;                   // Q.22 to Q.16
  localparam int RebW      = ClampW + CoordW;     // clamped projection times axis
  localparam int AccW      = RebW + 2;            // sum over three axes
  localparam int AccShift  = 28;                  // Q.36 to Q.8
  localparam int RndW      = AccW - AccShift + 1; // rounded offset
  localparam int SumW      = RndW + 1;            // center plus offset

  // Configuration register indexes.
  typedef enum logic [2:0] {
    RegCenter = 3'd0,
    RegHalf   = 3'd1,
    RegAxis0  = 3'd2,
    RegAxis1  = 3'd3,
    RegAxis2  = 3'd4
  } cfg_reg_t;

  // Reset values of the box registers.
  localparam logic [RegW-1:0] CenterReset = 48'h0000_0000_0000;
  localparam logic [RegW-1:0] HalfReset   = 48'h0100_0100_0100;
  localparam logic [RegW-1:0] Axis0Reset  = 48'h0000_0000_4000;
  localparam logic [RegW-1:0] Axis1Reset  = 48'h0000_4000_0000;
  localparam logic [RegW-1:0] Axis2Reset  = 48'h4000_0000_0000;

  // Box description as held in the configuration registers.
  typedef struct packed {
    logic [2:0][RegW-1:0] axis;
    logic [RegW-1:0]      half;
    logic [RegW-1:0]      center;
  } cfg_t;

  // Input item: one query point.
  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } in_t;

  // Result item.
  typedef struct packed {
    logic signed [CoordW-1:0] closest_x;
    logic signed [CoordW-1:0] closest_y;
    logic signed [CoordW-1:0] closest_z;
    logic [DistW-1:0]         distance_squared;
    logic                     inside_res;
  } out_t;

  // Projections onto the three axes, signed.
  typedef logic [2:0][ProjW-1:0] proj_t;

  // Rebuilt offset terms and squared excesses after the clamp.
  typedef struct packed {
    logic [2:0][2:0][RebW-1:0] reb;      // [axis][component], signed
    logic [2:0][SqW-1:0]       sq;
    logic                      outside;
  } clamp_t;

  // Signed 16-bit field k of a packed 48-bit register.
  function automatic logic signed [CoordW-1:0] field16(input logic [RegW-1:0] word,
                                                       input logic [1:0] k);
    return word[CoordW*k +: CoordW];
  endfunction

endpackage

// ===== design/obb_point_closest_distance_core.sv =====
// Top level of the oriented box closest point core: box registers and the
// seven-stage pipeline. Depends on obbcd_pkg, obbcd_proj, obbcd_clamp, obbcd_out.
//
//   Channel   Direction  Handshake                  Payload
//   point     in         point_valid / point_ready  in_t  (point_x, point_y, point_z)
//   result    out        result_valid / result_ready out_t (closest, distance, inside)
//   cfg       in         cfg_we                     cfg_idx, cfg_wdata
//
// One item enters per cycle while the output is not stalled; each result passes
// through the seven register stages (offset, products, dot product, clamp,
// square and rebuild, sums, rounding and saturation).
// Reset (rst, synchronous) empties the pipeline and loads the unit box.
// Each stage holds its item while the next one is full and stalled; empty
// stages still take items, so no item is lost or repeated.
module obb_point_closest_distance_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          point_valid,
  output logic                          point_ready,
  input  obbcd_pkg::in_t                point,
  output logic                          result_valid,
  input  logic                          result_ready,
  output obbcd_pkg::out_t               result,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_idx,
  input  logic [obbcd_pkg::RegW-1:0]    cfg_wdata
);
  import obbcd_pkg::*;

  cfg_t     box;
  logic     proj_valid, proj_ready;
  proj_t    proj;
  logic     clamp_valid, clamp_ready;
  clamp_t   clamp_res;

  // Box registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      box.center  <= CenterReset;
      box.half    <= HalfReset;
      box.axis[0] <= Axis0Reset;
      box.axis[1] <= Axis1Reset;
      box.axis[2] <= Axis2Reset;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        RegCenter: box.center  <= cfg_wdata;
        RegHalf:   box.half    <= cfg_wdata;
        RegAxis0:  box.axis[0] <= cfg_wdata;
        RegAxis1:  box.axis[1] <= cfg_wdata;
        RegAxis2:  box.axis[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  obbcd_proj u_proj (
    .clk       (clk),
    .rst       (rst),
    .box       (box),
    .in_valid  (point_valid),
    .in_ready  (point_ready),
    .pt        (point),
    .out_valid (proj_valid),
    .out_ready (proj_ready),
    .proj      (proj)
  );

  obbcd_clamp u_clamp (
    .clk       (clk),
    .rst       (rst),
    .box       (box),
    .in_valid  (proj_valid),
    .in_ready  (proj_ready),
    .proj      (proj),
    .out_valid (clamp_valid),
    .out_ready (clamp_ready),
    .res       (clamp_res)
  );

  obbcd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .box       (box),
    .in_valid  (clamp_valid),
    .in_ready  (clamp_ready),
    .cl        (clamp_res),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .res       (result)
  );

endmodule

// ===== design/obbcd_proj.sv =====
// Projection stages: offset from the center, per-axis products and their sums.
// Depends on obbcd_pkg.
module obbcd_proj (
  input  logic              clk,
  input  logic              rst,
  input  obbcd_pkg::cfg_t   box,
  input  logic              in_valid,
  output logic              in_ready,
  input  obbcd_pkg::in_t    pt,
  output logic              out_valid,
  input  logic              out_ready,
  output obbcd_pkg::proj_t  proj
);
  import obbcd_pkg::*;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  logic signed [CoordW-1:0] pt_c [3];
  logic signed [OffW-1:0]   off [3];
  logic signed [ProdW-1:0]  prod [3][3];

  // A stage takes a new item when it is empty or its item moves on.
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;

  always_comb begin
    pt_c[0] = pt.point_x;
    pt_c[1] = pt.point_y;
    pt_c[2] = pt.point_z;
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Stage 1: exact offset of the point from the box center.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < 3; i++) begin
        off[i] <= OffW'(pt_c[i]) - OffW'(field16(box.center, 2'(i)));
      end
    end
  end

  // Stage 2: offset times each axis component.
  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          prod[k][i] <= ProdW'(off[i]) * ProdW'(field16(box.axis[k], 2'(i)));
        end
      end
    end
  end

  // Stage 3: dot product per axis.
  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int k = 0; k < 3; k++) begin
        proj[k] <= ProjW'(prod[k][0]) + ProjW'(prod[k][1]) + ProjW'(prod[k][2]);
      end
    end
  end

endmodule

// ===== design/obbcd_clamp.sv =====
// Clamp stages: limit each projection to its half-extent, square the rounded
// excess and multiply the clamped projection back onto its axis. Depends on obbcd_pkg.
module obbcd_clamp (
  input  logic               clk,
  input  logic               rst,
  input  obbcd_pkg::cfg_t    box,
  input  logic               in_valid,
  output logic               in_ready,
  input  obbcd_pkg::proj_t   proj,
  output logic               out_valid,
  input  logic               out_ready,
  output obbcd_pkg::clamp_t  res
);
  import obbcd_pkg::*;

  logic v4, v5;
  logic rdy4, rdy5;
  logic signed [ProjW:0]    proj_x [3];
  logic signed [ProjW:0]    lim_x [3];
  logic signed [ProjW:0]    diff_hi [3];
  logic signed [ProjW:0]    diff_lo [3];
  logic signed [ClampW-1:0] clamp_next [3];
  logic [ExcW-1:0]          exc_next [3];
  logic [2:0]               out_next;
  logic signed [ClampW-1:0] clamped [3];
  logic [ExcW-1:0]          excess [3];
  logic [2:0]               outk;
  logic [ExcW:0]            exc_rnd [3];
  logic [E11W-1:0]          e11 [3];

  assign rdy5      = !v5 || out_ready;
  assign rdy4      = !v4 || rdy5;
  assign in_ready  = rdy4;
  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy4) v4 <= in_valid;
      if (rdy5) v5 <= v4;
    end
  end

  // Compare each projection with plus and minus its scaled half-extent.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      proj_x[k]  = $signed({proj[k][ProjW-1], proj[k]});
      lim_x[k]   = $signed({{(ProjW + 1 - LimW){1'b0}},
                            box.half[CoordW*k +: CoordW], {FracShift{1'b0}}});
      diff_hi[k] = proj_x[k] - lim_x[k];
      diff_lo[k] = -lim_x[k] - proj_x[k];
      if (proj_x[k] > lim_x[k]) begin
        clamp_next[k] = lim_x[k][ClampW-1:0];
        exc_next[k]   = diff_hi[k][ExcW-1:0];
        out_next[k]   = 1'b1;
      end else if (proj_x[k] < -lim_x[k]) begin
        clamp_next[k] = diff_lo[k][ClampW-1:0] + proj_x[k][ClampW-1:0];
        exc_next[k]   = diff_lo[k][ExcW-1:0];
        out_next[k]   = 1'b1;
      end else begin
        clamp_next[k] = proj_x[k][ClampW-1:0];
        exc_next[k]   = '0;
        out_next[k]   = 1'b0;
      end
    end
  end

  // Stage 4: clamped projection, excess and the per-axis outside flags.
  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int k = 0; k < 3; k++) begin
        clamped[k] <= clamp_next[k];
        excess[k]  <= exc_next[k];
      end
      outk <= out_next;
    end
  end

  // Round the excess to Q.11 with halves going up.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      exc_rnd[k] = {1'b0, excess[k]} + (ExcW + 1)'(1 << (ExcShift - 1));
      e11[k]     = exc_rnd[k][ExcW:ExcShift];
    end
  end

  // Stage 5: squared excess and the clamped projection times each component.
  always_ff @(posedge clk) begin
    if (rdy5) begin
      for (int k = 0; k < 3; k++) begin
        res.sq[k] <= SqW'(e11[k]) * SqW'(e11[k]);
        for (int i = 0; i < 3; i++) begin
          res.reb[k][i] <= RebW'(clamped[k]) * RebW'(field16(box.axis[k], 2'(i)));
        end
      end
      res.outside <= |outk;
    end
  end

endmodule

// ===== design/obbcd_out.sv =====
// Output stages: sum the rebuilt offsets and squared excesses, round, add the
// center and saturate into the result register. Depends on obbcd_pkg.
module obbcd_out (
  input  logic               clk,
  input  logic               rst,
  input  obbcd_pkg::cfg_t    box,
  input  logic               in_valid,
  output logic               in_ready,
  input  obbcd_pkg::clamp_t  cl,
  output logic               out_valid,
  input  logic               out_ready,
  output obbcd_pkg::out_t    res
);
  import obbcd_pkg::*;

  localparam logic [AccW:0]   AccHalf  = (AccW + 1)'(1) << (AccShift - 1);
  localparam logic [SqSumW:0] DistHalf = (SqSumW + 1)'(1) << (DistShift - 1);

  logic v6, v7;
  logic rdy6, rdy7;
  logic signed [AccW-1:0]   acc [3];
  logic [SqSumW-1:0]        sqsum;
  logic                     outside;
  logic signed [AccW:0]     acc_rnd [3];
  logic signed [RndW-1:0]   d [3];
  logic signed [SumW-1:0]   pos [3];
  logic signed [CoordW-1:0] sat [3];
  logic [SqSumW:0]          dist_rnd;
  logic [SqSumW-DistShift:0] dist_full;
  logic [DistW-1:0]         dist_sat;

  assign rdy7      = !v7 || out_ready;
  assign rdy6      = !v6 || rdy7;
  assign in_ready  = rdy6;
  assign out_valid = v7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy6) v6 <= in_valid;
      if (rdy7) v7 <= v6;
    end
  end

  // Stage 6: sum over the three axes.
  always_ff @(posedge clk) begin
    if (rdy6) begin
      for (int i = 0; i < 3; i++) begin
        acc[i] <= AccW'($signed(cl.reb[0][i])) + AccW'($signed(cl.reb[1][i]))
                + AccW'($signed(cl.reb[2][i]));
      end
      sqsum   <= SqSumW'(cl.sq[0]) + SqSumW'(cl.sq[1]) + SqSumW'(cl.sq[2]);
      outside <= cl.outside;
    end
  end

  // Round to Q.8 (floor of value plus one half), add the center, saturate.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_rnd[i] = (AccW + 1)'(acc[i]) + $signed(AccHalf);
      d[i]       = acc_rnd[i][AccW:AccShift];
      pos[i]     = SumW'(field16(box.center, 2'(i))) + SumW'(d[i]);
      if (!pos[i][SumW-1] && (|pos[i][SumW-2:CoordW-1])) begin
        sat[i] = {1'b0, {(CoordW - 1){1'b1}}};
      end else if (pos[i][SumW-1] && !(&pos[i][SumW-2:CoordW-1])) begin
        sat[i] = {1'b1, {(CoordW - 1){1'b0}}};
      end else begin
        sat[i] = pos[i][CoordW-1:0];
      end
    end
  end

  // Round the squared distance to Q.16 and saturate.
  always_comb begin
    dist_rnd  = {1'b0, sqsum} + DistHalf;
    dist_full = dist_rnd[SqSumW:DistShift];
    if (|dist_full[SqSumW-DistShift:DistW]) begin
      dist_sat = '1;
    end else begin
      dist_sat = dist_full[DistW-1:0];
    end
  end

  // Stage 7: result register.
  always_ff @(posedge clk) begin
    if (rdy7) begin
      res.closest_x        <= sat[0];
      res.closest_y        <= sat[1];
      res.closest_z        <= sat[2];
      res.distance_squared <= dist_sat;
      res.inside_res       <= !outside;
    end
  end

endmodule

// ===== design/obbcd_checker.sv =====
// Port-level checks for the oriented box closest point core, and the bind
// that attaches them. Depends on obbcd_pkg and obb_point_closest_distance_core.
module obbcd_assertions (
  input logic              clk,
  input logic              rst,
  input logic              point_ready,
  input logic              result_valid,
  input logic              result_ready,
  input obbcd_pkg::out_t   result
);
  import obbcd_pkg::*;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // A stalled result item holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result item changed");

  // A taken output frees every stage, so the input side is open.
  a_no_stall_ready: assert property (@(posedge clk) disable iff (rst)
    result_ready |-> point_ready)
    else $error("point_ready low while output is not stalled");

  // A contained point has zero distance.
  a_inside_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.inside_res |-> result.distance_squared == '0)
    else $error("inside_res set with nonzero distance");

endmodule

bind obb_point_closest_distance_core obbcd_assertions u_checker (.*);
